// ===== rtl/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types, constants and codes of the pixel HSV color classifier.
// ----------------------------------------------------------------------------
package phc_pkg;

    // Field widths.
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned HUE_W      = 9;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 9;

    // Long division lanes: numerator, divisor and quotient widths.
    localparam int unsigned NUM_W    = 18;
    localparam int unsigned DEN_W    = 9;
    localparam int unsigned QUO_W    = 9;
    localparam int unsigned DIV_BITS = 3;

    // Q16 color conversion coefficients.
    localparam logic signed [26:0] K_CR_TO_R = 27'sd92242;
    localparam logic signed [26:0] K_CB_TO_G = 27'sd22643;
    localparam logic signed [26:0] K_CR_TO_G = 27'sd46983;
    localparam logic signed [26:0] K_CB_TO_B = 27'sd116589;

    // Value percent: floor(x / 510) as (x * VAL_RECIP) >> 25 for x below 2^16.
    localparam logic [32:0] VAL_RECIP = 33'd65794;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK_VAL_MAX  = 3'd0,
        REG_WHITE_SAT_MAX  = 3'd1,
        REG_HUE_LOW        = 3'd2,
        REG_HUE_HIGH       = 3'd3,
        REG_MARK_LUMA      = 3'd4,
        REG_MARK_CB        = 3'd5,
        REG_MARK_CR        = 3'd6
    } t_reg_idx;

    // Pixel classes.
    typedef enum logic [1:0] {
        CLS_BLACK  = 2'd0,
        CLS_WHITE  = 2'd1,
        CLS_MARKED = 2'd2,
        CLS_OTHER  = 2'd3
    } t_class;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } t_yuv;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } t_rgb;

    // Per-pixel data that travels alongside the division lanes.
    typedef struct packed {
        t_yuv             yuv;
        t_rgb             rgb;
        logic [PCT_W-1:0] val;
    } t_px;

    // One restoring division in flight.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic [PCT_W-1:0] black_val_max;
        logic [PCT_W-1:0] white_sat_max;
        logic [HUE_W-1:0] hue_low;
        logic [HUE_W-1:0] hue_high;
        t_yuv             mark;
    } t_cfg;

endpackage

// ===== rtl/pixel_hsv_color_classifier.sv =====
// ----------------------------------------------------------------------------
// pixel_hsv_color_classifier
// Converts YUV pixels to RGB and rounded HSV, classes each pixel and
// substitutes a marker color for pixels inside the configured hue window.
// ----------------------------------------------------------------------------
// Pipeline: 7 register stages from input transfer to result valid (products,
// clamp, HSV setup, three divider stages, output).
// Throughput: one pixel per cycle; each stage holds its item under stall and
// empty stages fill up while the output waits.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// configuration registers with their defaults.
module pixel_hsv_color_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input: [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,
    // Result: [7:0] red, [15:8] green, [23:16] blue, [32:24] hue,
    // [39:33] saturation, [46:40] brightness, [54:47] out_luma,
    // [62:55] out_cb, [70:63] out_cr, [71] zero.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,
    // Result kind: [1:0] pixel_class.
    output logic [1:0]  o_m_tuser,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import phc_pkg::*;

    localparam int NUM_STAGES = 7;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;
    t_cfg                  r_cfg;
    t_yuv                  w_yuv;
    t_px                   w_px_rgb;
    t_px                   w_px_prep;
    t_px                   w_px_d0;
    t_px                   w_px_d1;
    t_px                   w_px_d2;
    t_div_lane             w_hue_prep;
    t_div_lane             w_hue_d0;
    t_div_lane             w_hue_d1;
    t_div_lane             w_hue_d2;
    t_div_lane             w_sat_prep;
    t_div_lane             w_sat_d0;
    t_div_lane             w_sat_d1;
    t_div_lane             w_sat_d2;

    // A stage loads when it is empty or its successor loads.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Configuration registers, written as given and masked to width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.black_val_max <= 7'd35;
            r_cfg.white_sat_max <= 7'd10;
            r_cfg.hue_low       <= 9'd25;
            r_cfg.hue_high      <= 9'd130;
            r_cfg.mark.luma     <= 8'd210;
            r_cfg.mark.cb       <= 8'd16;
            r_cfg.mark.cr       <= 8'd146;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BLACK_VAL_MAX: r_cfg.black_val_max <= i_cfg_data[PCT_W-1:0];
                REG_WHITE_SAT_MAX: r_cfg.white_sat_max <= i_cfg_data[PCT_W-1:0];
                REG_HUE_LOW:       r_cfg.hue_low       <= i_cfg_data;
                REG_HUE_HIGH:      r_cfg.hue_high      <= i_cfg_data;
                REG_MARK_LUMA:     r_cfg.mark.luma     <= i_cfg_data[PIX_W-1:0];
                REG_MARK_CB:       r_cfg.mark.cb       <= i_cfg_data[PIX_W-1:0];
                REG_MARK_CR:       r_cfg.mark.cr       <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_en[0];
    assign o_m_tvalid  = r_vld[NUM_STAGES-1];

    assign w_yuv.luma = i_s_tdata[7:0];
    assign w_yuv.cb   = i_s_tdata[15:8];
    assign w_yuv.cr   = i_s_tdata[23:16];

    // Color conversion.
    phc_rgb u_rgb (
        .i_clk      (i_clk),
        .i_en_mul   (w_en[0]),
        .i_en_clamp (w_en[1]),
        .i_yuv      (w_yuv),
        .o_px       (w_px_rgb)
    );

    // HSV setup.
    phc_hsv_prep u_prep (
        .i_clk (i_clk),
        .i_en  (w_en[2]),
        .i_px  (w_px_rgb),
        .o_px  (w_px_prep),
        .o_hue (w_hue_prep),
        .o_sat (w_sat_prep)
    );

    // Divider, three quotient bits per stage.
    phc_div_stage #(.BIT_HI(8)) u_div0 (
        .i_clk (i_clk),
        .i_en  (w_en[3]),
        .i_px  (w_px_prep),
        .i_hue (w_hue_prep),
        .i_sat (w_sat_prep),
        .o_px  (w_px_d0),
        .o_hue (w_hue_d0),
        .o_sat (w_sat_d0)
    );

    phc_div_stage #(.BIT_HI(5)) u_div1 (
        .i_clk (i_clk),
        .i_en  (w_en[4]),
        .i_px  (w_px_d0),
        .i_hue (w_hue_d0),
        .i_sat (w_sat_d0),
        .o_px  (w_px_d1),
        .o_hue (w_hue_d1),
        .o_sat (w_sat_d1)
    );

    phc_div_stage #(.BIT_HI(2)) u_div2 (
        .i_clk (i_clk),
        .i_en  (w_en[5]),
        .i_px  (w_px_d1),
        .i_hue (w_hue_d1),
        .i_sat (w_sat_d1),
        .o_px  (w_px_d2),
        .o_hue (w_hue_d2),
        .o_sat (w_sat_d2)
    );

    // Classification and output register.
    phc_classify u_classify (
        .i_clk   (i_clk),
        .i_en    (w_en[6]),
        .i_px    (w_px_d2),
        .i_hue   (w_hue_d2.quo),
        .i_sat   (w_sat_d2.quo),
        .i_cfg   (r_cfg),
        .o_tdata (o_m_tdata),
        .o_tuser (o_m_tuser)
    );

endmodule

// ===== rtl/phc_rgb.sv =====
// ----------------------------------------------------------------------------
// phc_rgb
// Two pipeline stages: Q16 YUV to RGB products and sums, then truncate and clamp.
// ----------------------------------------------------------------------------
module phc_rgb (
    input  logic          i_clk,
    input  logic          i_en_mul,
    input  logic          i_en_clamp,
    input  phc_pkg::t_yuv i_yuv,
    output phc_pkg::t_px  o_px
);
    import phc_pkg::*;

    logic signed [8:0]  w_cb;
    logic signed [8:0]  w_cr;
    logic signed [26:0] w_luma_q;
    logic signed [26:0] n_sum_r;
    logic signed [26:0] n_sum_g;
    logic signed [26:0] n_sum_b;
    logic signed [26:0] r_sum_r;
    logic signed [26:0] r_sum_g;
    logic signed [26:0] r_sum_b;
    t_yuv               r_yuv;
    t_px                r_px;

    // Negative sums clamp to zero, sums of 256.0 and above clamp to 255.
    function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [26:0] sum);
        logic [PIX_W-1:0] res;
        if (sum[26]) begin
            res = '0;
        end else if (sum[25:24] != 2'b00) begin
            res = '1;
        end else begin
            res = sum[23:16];
        end
        return res;
    endfunction

    // Centered chroma and the weighted sums.
    always_comb begin
        w_cb     = $signed({1'b0, i_yuv.cb}) - 9'sd128;
        w_cr     = $signed({1'b0, i_yuv.cr}) - 9'sd128;
        w_luma_q = $signed({3'b000, i_yuv.luma, 16'h0000});
        n_sum_r  = w_luma_q + 27'(w_cr) * K_CR_TO_R;
        n_sum_g  = w_luma_q - 27'(w_cb) * K_CB_TO_G - 27'(w_cr) * K_CR_TO_G;
        n_sum_b  = w_luma_q + 27'(w_cb) * K_CB_TO_B;
    end

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
            r_yuv   <= i_yuv;
        end
    end

    // Clamp stage.
    always_ff @(posedge i_clk) begin
        if (i_en_clamp) begin
            r_px.yuv   <= r_yuv;
            r_px.rgb.r <= clamp_q16(r_sum_r);
            r_px.rgb.g <= clamp_q16(r_sum_g);
            r_px.rgb.b <= clamp_q16(r_sum_b);
            r_px.val   <= '0;
        end
    end

    assign o_px = r_px;

endmodule

// ===== rtl/phc_hsv_prep.sv =====
// ----------------------------------------------------------------------------
// phc_hsv_prep
// One pipeline stage: max, min, value percent, and the hue and saturation
// numerators and divisors for the division stages.
// ----------------------------------------------------------------------------
module phc_hsv_prep (
    input  logic               i_clk,
    input  logic               i_en,
    input  phc_pkg::t_px       i_px,
    output phc_pkg::t_px       o_px,
    output phc_pkg::t_div_lane o_hue,
    output phc_pkg::t_div_lane o_sat
);
    import phc_pkg::*;

    logic [PIX_W-1:0]  w_mx;
    logic [PIX_W-1:0]  w_mn;
    logic [PIX_W-1:0]  w_d;
    logic signed [8:0] w_diff;
    logic signed [19:0] w_n;
    logic signed [19:0] w_d_s;
    logic [15:0]       w_val_x;
    logic [32:0]       w_val_prod;
    t_div_lane         n_hue;
    t_div_lane         n_sat;
    t_px               n_px;
    t_px               r_px;
    t_div_lane         r_hue;
    t_div_lane         r_sat;

    always_comb begin
        // Maximum and minimum of the three components.
        w_mx = i_px.rgb.r;
        if (i_px.rgb.g > w_mx) w_mx = i_px.rgb.g;
        if (i_px.rgb.b > w_mx) w_mx = i_px.rgb.b;
        w_mn = i_px.rgb.r;
        if (i_px.rgb.g < w_mn) w_mn = i_px.rgb.g;
        if (i_px.rgb.b < w_mn) w_mn = i_px.rgb.b;
        w_d   = w_mx - w_mn;
        w_d_s = $signed({12'h000, w_d});

        // Hue numerator in degrees times the spread; red wins ties.
        if (w_mx == i_px.rgb.r) begin
            w_diff = $signed({1'b0, i_px.rgb.g}) - $signed({1'b0, i_px.rgb.b});
            w_n    = 20'(w_diff) * 20'sd60;
            if (w_n < 0) w_n = w_n + 20'sd360 * w_d_s;
        end else if (w_mx == i_px.rgb.g) begin
            w_diff = $signed({1'b0, i_px.rgb.b}) - $signed({1'b0, i_px.rgb.r});
            w_n    = 20'(w_diff) * 20'sd60 + 20'sd120 * w_d_s;
        end else begin
            w_diff = $signed({1'b0, i_px.rgb.r}) - $signed({1'b0, i_px.rgb.g});
            w_n    = 20'(w_diff) * 20'sd60 + 20'sd240 * w_d_s;
        end

        // Rounded half up as floor((2N + d) / 2d); a grey pixel divides zero by one.
        n_hue.rem = NUM_W'(2 * w_n + w_d_s);
        n_hue.den = (w_d == '0) ? DEN_W'(1) : {w_d, 1'b0};
        n_hue.quo = '0;

        n_sat.rem = NUM_W'(18'd200 * NUM_W'(w_d) + NUM_W'(w_mx));
        n_sat.den = (w_mx == '0) ? DEN_W'(1) : {w_mx, 1'b0};
        n_sat.quo = '0;

        // Value percent by reciprocal multiplication.
        w_val_x    = 16'(16'd200 * 16'(w_mx) + 16'd255);
        w_val_prod = 33'(w_val_x) * VAL_RECIP;

        n_px     = i_px;
        n_px.val = w_val_prod[31:25];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= n_px;
            r_hue <= n_hue;
            r_sat <= n_sat;
        end
    end

    assign o_px  = r_px;
    assign o_hue = r_hue;
    assign o_sat = r_sat;

endmodule

// ===== rtl/phc_div_stage.sv =====
// ----------------------------------------------------------------------------
// phc_div_stage
// One stage of the pipelined restoring divider: resolves three quotient bits
// of the hue and saturation lanes, from BIT_HI down.
// ----------------------------------------------------------------------------
module phc_div_stage #(
    parameter int BIT_HI = 8
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  phc_pkg::t_px       i_px,
    input  phc_pkg::t_div_lane i_hue,
    input  phc_pkg::t_div_lane i_sat,
    output phc_pkg::t_px       o_px,
    output phc_pkg::t_div_lane o_hue,
    output phc_pkg::t_div_lane o_sat
);
    import phc_pkg::*;

    t_px       r_px;
    t_div_lane r_hue;
    t_div_lane r_sat;

    // Compare and subtract the shifted divisor, top bit first.
    function automatic t_div_lane div_step(input t_div_lane lane);
        t_div_lane        res;
        logic [NUM_W-1:0] sub;
        logic [3:0]       bi;
        res = lane;
        for (int j = 0; j < DIV_BITS; j++) begin
            bi  = 4'(BIT_HI - j);
            sub = NUM_W'(res.den) << bi;
            if (res.rem >= sub) begin
                res.rem     = res.rem - sub;
                res.quo[bi] = 1'b1;
            end
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= i_px;
            r_hue <= div_step(i_hue);
            r_sat <= div_step(i_sat);
        end
    end

    assign o_px  = r_px;
    assign o_hue = r_hue;
    assign o_sat = r_sat;

endmodule

// ===== rtl/phc_classify.sv =====
// ----------------------------------------------------------------------------
// phc_classify
// Output stage: classes the pixel, substitutes the marker color and packs
// the result transfer.
// ----------------------------------------------------------------------------
module phc_classify (
    input  logic          i_clk,
    input  logic          i_en,
    input  phc_pkg::t_px  i_px,
    input  logic [8:0]    i_hue,
    input  logic [8:0]    i_sat,
    input  phc_pkg::t_cfg i_cfg,
    output logic [71:0]   o_tdata,
    output logic [1:0]    o_tuser
);
    import phc_pkg::*;

    t_class       n_class;
    t_yuv         n_yuv;
    logic [71:0]  r_tdata;
    logic [1:0]   r_tuser;

    // Black wins over white, white over the hue window.
    always_comb begin
        if (i_px.val <= i_cfg.black_val_max) begin
            n_class = CLS_BLACK;
        end else if (i_sat[PCT_W-1:0] <= i_cfg.white_sat_max) begin
            n_class = CLS_WHITE;
        end else if (i_hue >= i_cfg.hue_low && i_hue <= i_cfg.hue_high) begin
            n_class = CLS_MARKED;
        end else begin
            n_class = CLS_OTHER;
        end
        n_yuv = (n_class == CLS_MARKED) ? i_cfg.mark : i_px.yuv;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tdata <= {1'b0, n_yuv.cr, n_yuv.cb, n_yuv.luma, i_px.val,
                        i_sat[PCT_W-1:0], i_hue, i_px.rgb.b, i_px.rgb.g, i_px.rgb.r};
            r_tuser <= n_class;
        end
    end

    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;

endmodule

// ===== tb/sv/phc_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phc_result_checker
// Watches the pixel, result and configuration channels of the classifier,
// predicts each result from its own copy of the registers and compares.
// ----------------------------------------------------------------------------
module phc_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import phc_pkg::*;

    typedef struct packed {
        logic [1:0]  cls;
        logic [71:0] data;
    } t_pix_result;

    t_pix_result expected_q[$];
    t_cfg        cfg;
    int          class_seen[4];

    assign o_pending = expected_q.size();

    // Clamp a Q16 sum to a byte.
    function automatic logic [7:0] q16_to_byte(longint sum);
        longint v;
        if (sum < 0) return 8'd0;
        v = sum / 65536;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Predict the result of one pixel under the current registers.
    function automatic t_pix_result classify_pixel(logic [23:0] px);
        longint y, cb, cr, r, g, b, mx, mn, d, n;
        longint hue, sat, val;
        t_class cls;
        t_pix_result res;
        y  = px[7:0];
        cb = longint'(px[15:8]) - 128;
        cr = longint'(px[23:16]) - 128;
        r  = q16_to_byte(y * 65536 + 92242 * cr);
        g  = q16_to_byte(y * 65536 - 22643 * cb - 46983 * cr);
        b  = q16_to_byte(y * 65536 + 116589 * cb);
        mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
        mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
        d  = mx - mn;
        val = (200 * mx + 255) / 510;
        sat = (mx != 0) ? (200 * d + mx) / (2 * mx) : 0;
        hue = 0;
        if (d != 0) begin
            if (mx == r) begin
                n = 60 * (g - b);
                if (n < 0) n += 360 * d;
            end else if (mx == g) begin
                n = 60 * (b - r) + 120 * d;
            end else begin
                n = 60 * (r - g) + 240 * d;
            end
            hue = (2 * n + d) / (2 * d);
        end
        if (val <= cfg.black_val_max) cls = CLS_BLACK;
        else if (sat <= cfg.white_sat_max) cls = CLS_WHITE;
        else if (hue >= cfg.hue_low && hue <= cfg.hue_high) cls = CLS_MARKED;
        else cls = CLS_OTHER;
        res.cls = cls;
        res.data = '0;
        res.data[7:0]   = r[7:0];
        res.data[15:8]  = g[7:0];
        res.data[23:16] = b[7:0];
        res.data[32:24] = hue[8:0];
        res.data[39:33] = sat[6:0];
        res.data[46:40] = val[6:0];
        res.data[70:47] = (cls == CLS_MARKED) ?
            {cfg.mark.cr, cfg.mark.cb, cfg.mark.luma} : px;
        return res;
    endfunction

    // Track registers, queue predictions and compare results.
    always @(posedge i_clk) begin
        t_pix_result want;
        if (!i_rst_n) begin
            cfg.black_val_max <= 7'd35;
            cfg.white_sat_max <= 7'd10;
            cfg.hue_low       <= 9'd25;
            cfg.hue_high      <= 9'd130;
            cfg.mark          <= '{luma: 8'd210, cb: 8'd16, cr: 8'd146};
            expected_q.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) expected_q.push_back(classify_pixel(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h/%0d", $realtime, i_m_tdata,
                             i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    class_seen[want.cls]++;
                    if (want.data !== i_m_tdata || want.cls !== i_m_tuser) begin
                        $display("%0t: mismatch expected %h/%0d actual %h/%0d",
                                 $realtime, want.data, want.cls, i_m_tdata, i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_BLACK_VAL_MAX: cfg.black_val_max <= i_cfg_data[6:0];
                    REG_WHITE_SAT_MAX: cfg.white_sat_max <= i_cfg_data[6:0];
                    REG_HUE_LOW:       cfg.hue_low       <= i_cfg_data;
                    REG_HUE_HIGH:      cfg.hue_high      <= i_cfg_data;
                    REG_MARK_LUMA:     cfg.mark.luma     <= i_cfg_data[7:0];
                    REG_MARK_CB:       cfg.mark.cb       <= i_cfg_data[7:0];
                    REG_MARK_CR:       cfg.mark.cr       <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Class mix of the run, printed by the top before its verdict.
    function automatic void report_classes();
        $display("Classes seen: black %0d, white %0d, marked %0d, other %0d.",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
    endfunction

endmodule

// ===== tb/sv/tb_pixel_hsv_color_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_hsv_color_classifier
// Drives directed and random pixels through the classifier under several
// register settings and idling patterns; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_pixel_hsv_color_classifier;
    import phc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    int          errors, pending, results;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    int          idle_cycles = 0, pixels_sent = 0, cfg_writes = 0;
    bit          timed_out = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    pixel_hsv_color_classifier u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    phc_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Watchdog expired at %0t.", $realtime);
            $display("FAIL");
            $finish;
        end
    end

    // Valid stays high from one pixel to the next; it drops only while idling.
    task automatic send_pixel(input logic [23:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    // Wait until every result is in, then let the pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_all(input int bmax, input int wmax, input int hlo, input int hhi,
                           input int ml, input int mcb, input int mcr);
        write_reg(REG_BLACK_VAL_MAX, 9'(bmax));
        write_reg(REG_WHITE_SAT_MAX, 9'(wmax));
        write_reg(REG_HUE_LOW, 9'(hlo));
        write_reg(REG_HUE_HIGH, 9'(hhi));
        write_reg(REG_MARK_LUMA, 9'(ml));
        write_reg(REG_MARK_CB, 9'(mcb));
        write_reg(REG_MARK_CR, 9'(mcr));
    endtask

    // Random pixels: mostly mid-range luma with random chroma, some raw noise.
    task automatic random_pixels(input int count);
        logic [23:0] px;
        repeat (count) begin
            px = 24'($urandom);
            if ($urandom_range(3) != 0) px[7:0] = 8'($urandom_range(60, 220));
            send_pixel(px);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, grey, pure colors, hue near a full turn.
        send_pixel({8'd128, 8'd128, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd255, 8'd255});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd128, 8'd128, 8'd255});
        send_pixel({8'd255, 8'd0, 8'd128});
        send_pixel({8'd0, 8'd128, 8'd128});
        send_pixel({8'd200, 8'd100, 8'd120});
        send_pixel({8'd140, 8'd131, 8'd100});
        send_pixel({8'd150, 8'd60, 8'd150});
        send_pixel({8'd60, 8'd200, 8'd150});
        send_pixel({8'd129, 8'd128, 8'd80});
        send_pixel({8'd170, 8'd170, 8'd170});
        send_pixel({8'd90, 8'd20, 8'd100});
        wait_drained();

        // Reversed hue window, and extreme registers beyond range.
        set_all(0, 0, 300, 20, 0, 255, 0);
        random_pixels(60);
        wait_drained();
        set_all(127, 127, 511, 511, 255, 0, 255);
        random_pixels(30);
        wait_drained();
        set_all(0, 0, 0, 360, 85, 170, 51);
        random_pixels(40);
        wait_drained();
        write_reg(REG_MARK_LUMA, 9'h1AA);
        write_reg(REG_MARK_CB, 9'h155);
        write_reg(REG_MARK_CR, 9'h1FF);
        write_reg(t_reg_idx'(3'd7), 9'd5);

        // Idling phases under random settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            random_pixels(125);
            wait_drained();
            set_all($urandom_range(60), $urandom_range(60), $urandom_range(360),
                    $urandom_range(360), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255));
        end
        recv_stall_pct = 0;
        wait_drained();

        $display("Sent %0d pixels, checked %0d results, made %0d register writes.",
                 pixels_sent, results, cfg_writes);
        u_checker.report_classes();
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
